### rtl/ple_pkg.sv
package ple_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned ST_W         = 3;
  localparam int unsigned CAPACITY_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_EVEN   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE      = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BADPOS    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NONE_EVEN = 3'd4,
    ST_ENTRY     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic edit;
    logic empty_rsp;
    logic scan_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_edit;
    logic list_empty;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

### rtl/ple_ctrl.sv
module ple_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  ple_pkg::sts_t sts_i,
  output ple_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  ple_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ple_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ple_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ple_pkg::S_EXEC;
      end
      ple_pkg::S_EXEC: begin
        if (sts_i.out_free) begin
          if (sts_i.is_edit || sts_i.list_empty) state_d = ple_pkg::S_IDLE;
          else state_d = ple_pkg::S_SCAN;
        end
      end
      ple_pkg::S_SCAN: begin
        if (sts_i.out_free && sts_i.scan_end) state_d = ple_pkg::S_FINISH;
      end
      ple_pkg::S_FINISH: begin
        if (sts_i.out_free) state_d = ple_pkg::S_IDLE;
      end
      default: state_d = ple_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ple_pkg::S_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ple_pkg::S_EXEC: begin
        cmd_o.edit      = sts_i.out_free && sts_i.is_edit;
        cmd_o.empty_rsp = sts_i.out_free && !sts_i.is_edit && sts_i.list_empty;
      end
      ple_pkg::S_SCAN: begin
        cmd_o.scan_step = sts_i.out_free;
      end
      ple_pkg::S_FINISH: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

### rtl/ple_dp.sv
module ple_dp #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ple_pkg::cmd_t                     cmd_i,
  output ple_pkg::sts_t                     sts_o,
  input  logic [ple_pkg::OP_W-1:0]          operation_i,
  input  logic [ple_pkg::POS_W-1:0]         position_i,
  input  logic signed [ple_pkg::DATA_W-1:0] new_value_i,
  output logic [ple_pkg::ST_W-1:0]          status_o,
  output logic signed [ple_pkg::DATA_W-1:0] entry_value_o,
  output logic                              last_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned PW    = ple_pkg::POS_W;
  localparam int unsigned DW    = ple_pkg::DATA_W;

  ple_pkg::op_e         op_q;
  logic [PW-1:0]        pos_q;
  logic signed [DW-1:0] val_q;

  logic signed [DW-1:0] ent_q [CAPACITY];
  logic signed [DW-1:0] ent_d [CAPACITY];

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_m1;
  logic             pend_valid_q, pend_valid_d;
  logic signed [DW-1:0] pend_q, pend_d;

  logic                 out_valid_q, out_valid_d;
  ple_pkg::status_e     out_status_q, out_status_d;
  logic signed [DW-1:0] out_value_q, out_value_d;
  logic                 out_last_q, out_last_d;
  logic                 out_load;

  logic [PW:0]      pos_ext, cnt_ext;
  logic [PW-1:0]    pidx;
  logic             is_ins, is_del, even_only;
  logic             bad_ins, bad_del, full, empty;
  logic             ins_ok, del_ok, cand;
  ple_pkg::status_e edit_status;

  assign is_ins    = (op_q == ple_pkg::OP_INSERT);
  assign is_del    = (op_q == ple_pkg::OP_DELETE);
  assign even_only = (op_q == ple_pkg::OP_EVEN);
  assign pos_ext   = {1'b0, pos_q};
  assign cnt_ext   = (PW + 1)'(count_q);
  assign pidx      = pos_q - 1'b1;
  assign cnt_m1    = count_q - 1'b1;
  assign empty     = (count_q == '0);
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign bad_ins   = (pos_q == '0) || (pos_ext > cnt_ext + 1'b1);
  assign bad_del   = (pos_q == '0) || (pos_ext > cnt_ext);
  assign ins_ok    = cmd_i.edit && is_ins && !bad_ins && !full;
  assign del_ok    = cmd_i.edit && is_del && !empty && !bad_del;
  assign cand      = !even_only || !ent_q[0][0];

  always_comb begin
    priority if (is_ins && bad_ins) begin
      edit_status = ple_pkg::ST_BADPOS;
    end else if (is_ins && full) begin
      edit_status = ple_pkg::ST_FULL;
    end else if (!is_ins && empty) begin
      edit_status = ple_pkg::ST_EMPTY;
    end else if (!is_ins && bad_del) begin
      edit_status = ple_pkg::ST_BADPOS;
    end else begin
      edit_status = ple_pkg::ST_DONE;
    end
  end

  // one lane per entry: shift up, shift down or rotate within the list
  for (genvar i = 0; i < CAPACITY; i++) begin : g_lane
    logic signed [DW-1:0] prv, nxt;
    if (i > 0) begin : g_prv
      assign prv = ent_q[i-1];
    end else begin : g_prv0
      assign prv = ent_q[i];
    end
    if (i < CAPACITY - 1) begin : g_nxt
      assign nxt = ent_q[i+1];
    end else begin : g_nxt0
      assign nxt = ent_q[i];
    end

    always_comb begin
      ent_d[i] = ent_q[i];
      priority if (ins_ok) begin
        if (PW'(i) > pidx) ent_d[i] = prv;
        else if (PW'(i) == pidx) ent_d[i] = val_q;
      end else if (del_ok) begin
        if (PW'(i) >= pidx) ent_d[i] = nxt;
      end else if (cmd_i.scan_step) begin
        if (CNT_W'(i) == cnt_m1) ent_d[i] = ent_q[0];
        else if (CNT_W'(i) < cnt_m1) ent_d[i] = nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < CAPACITY; k++) begin
      ent_q[k] <= ent_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= ple_pkg::op_e'(operation_i);
      pos_q <= position_i;
      val_q <= new_value_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok) count_d = count_q + 1'b1;
    else if (del_ok) count_d = count_q - 1'b1;
  end

  always_comb begin
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    if (cmd_i.capture) begin
      idx_d        = '0;
      pend_valid_d = 1'b0;
    end else if (cmd_i.scan_step) begin
      idx_d = idx_q + 1'b1;
      if (cand) begin
        pend_valid_d = 1'b1;
        pend_d       = ent_q[0];
      end
    end
  end

  // output word, loaded only when the slot is free
  always_comb begin
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    priority if (cmd_i.edit) begin
      out_load     = 1'b1;
      out_status_d = edit_status;
      out_value_d  = '0;
      out_last_d   = 1'b1;
    end else if (cmd_i.empty_rsp) begin
      out_load     = 1'b1;
      out_status_d = ple_pkg::ST_EMPTY;
      out_value_d  = '0;
      out_last_d   = 1'b1;
    end else if (cmd_i.scan_step && cand && pend_valid_q) begin
      out_load     = 1'b1;
      out_status_d = ple_pkg::ST_ENTRY;
      out_value_d  = pend_q;
      out_last_d   = 1'b0;
    end else if (cmd_i.finish) begin
      out_load     = 1'b1;
      out_status_d = pend_valid_q ? ple_pkg::ST_ENTRY : ple_pkg::ST_NONE_EVEN;
      out_value_d  = pend_valid_q ? pend_q : '0;
      out_last_d   = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q       <= pend_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
  end

  assign sts_o.is_edit    = is_ins || is_del;
  assign sts_o.list_empty = empty;
  assign sts_o.scan_end   = (idx_q == cnt_m1);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign status_o      = out_status_q;
  assign entry_value_o = out_value_q;
  assign last_o        = out_last_q;
  assign out_valid_o   = out_valid_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_edit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.edit |=> $stable(count_q))
    else $error("entry count moved outside an edit");

  a_pend_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |=> !pend_valid_q)
    else $error("pending entry survived a new word");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("held output word overwritten");

endmodule

### rtl/positional_list_engine_unit.sv
// channel | direction | handshake              | payload
// input   | in        | in_valid_i / in_stall_o  | operation_i, position_i, new_value_i
// output  | out       | out_valid_o / out_stall_i | status_o, entry_value_o, last_o
//
// insert and delete take a capture step per word, then an edit step
// dump/even-scan: capture, an empty check that ends an empty list, then the entry array
// rotates one entry per cycle through lane 0, and a final step releases the held entry
// rst_ni clears the entry count and control; entry contents are not reset
// a stalled output freezes the edit, scan and finish steps until the slot frees
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ple_pkg::OP_W-1:0]          operation_i,
  input  logic [ple_pkg::POS_W-1:0]         position_i,
  input  logic signed [ple_pkg::DATA_W-1:0] new_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ple_pkg::ST_W-1:0]          status_o,
  output logic signed [ple_pkg::DATA_W-1:0] entry_value_o,
  output logic                              last_o
);

  ple_pkg::cmd_t cmd;
  ple_pkg::sts_t sts;
  logic          busy;

  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  ple_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .new_value_i   (new_value_i),
    .status_o      (status_o),
    .entry_value_o (entry_value_o),
    .last_o        (last_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i)
  );

  assign in_stall_o = busy;

endmodule
